[hw/rtl/alu_with_status_flags_unit_assert.svh]
// Assertion macros for the status-flag ALU.
// Used by alu_with_status_flags_unit; no other dependencies.
`ifndef ALU_WITH_STATUS_FLAGS_UNIT_ASSERT_SVH
`define ALU_WITH_STATUS_FLAGS_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Implication checked on every edge outside reset.
`define ALU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ALU assertion failed");
// Same, but also checked while reset is asserted.
`define ALU_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("ALU assertion failed");
`else
`define ALU_ASSERT(lbl, clk, rst_n, prop)
`define ALU_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[hw/rtl/alu_flg_pkg.sv]
// Types and constants for the 16-bit status-flag ALU.
// No dependencies.
package alu_flg_pkg;

    localparam int unsigned WORD_W = 16;

    localparam logic [WORD_W-1:0] SIGN_MASK = 16'h8000;
    localparam logic [WORD_W-1:0] HIGH_BYTE = 16'hFF00;

    typedef enum logic [3:0] {
        OP_RRC  = 4'd0,
        OP_SWPB = 4'd1,
        OP_RRA  = 4'd2,
        OP_SXT  = 4'd3,
        OP_MOV  = 4'd4,
        OP_ADD  = 4'd5,
        OP_ADDC = 4'd6,
        OP_SUBC = 4'd7,
        OP_SUB  = 4'd8,
        OP_CMP  = 4'd9,
        OP_BIT  = 4'd10,
        OP_BIC  = 4'd11,
        OP_BIS  = 4'd12,
        OP_XOR  = 4'd13,
        OP_AND  = 4'd14
    } t_alu_op;

    typedef struct packed {
        logic [3:0]        op;
        logic [WORD_W-1:0] src_value;
        logic [WORD_W-1:0] dst_value;
    } t_alu_in;

    typedef struct packed {
        logic [WORD_W-1:0] result;
        logic              write_back;
        logic              carry_out;
        logic              zero_out;
        logic              negative_out;
        logic              overflow_out;
    } t_alu_out;

    typedef struct packed {
        logic v;
        logic n;
        logic z;
        logic c;
    } t_flags;

endpackage

[hw/rtl/alu_with_status_flags_unit.sv]
// 16-bit word ALU with carry, zero, negative and overflow flags.
// Depends on alu_flg_pkg and alu_with_status_flags_unit_assert.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_word) carries one word:
//   op code, source and destination operands. Output channel (o_out_valid /
//   i_out_ready / o_out_word) returns one word per input: result,
//   write-back enable and the four flags after the operation.
//   A word passes an input register, one pass of ALU logic, then the
//   result register before o_out_valid shows it to the receiver.
//   Throughput is one word per cycle while the receiver does not stall;
//   the flag register closes a loop so ADDC, SUBC and RRC always see the
//   carry of the previous word.
//   When the receiver stalls the result register holds and the input
//   register stays full; o_in_ready drops only once both are occupied, so
//   up to two words can be in flight.
//   Synchronous active-low reset empties both registers and clears flags.
//   Op code 15 returns result 0, no write-back and the flags unchanged.
module alu_with_status_flags_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  alu_flg_pkg::t_alu_in  i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output alu_flg_pkg::t_alu_out o_out_word
);
    import alu_flg_pkg::*;

`include "alu_with_status_flags_unit_assert.svh"

    logic     r_s1_valid;
    t_alu_in  r_s1;
    logic     r_out_valid;
    t_alu_out r_out;
    t_flags   r_flags;

    logic     s1_advance;
    t_flags   n_flags;
    t_alu_out n_out;

    logic              is_sub;
    logic [WORD_W-1:0] add_b;
    logic              add_cin;
    logic [WORD_W:0]   sum;
    t_flags            add_flags;

    logic [WORD_W-1:0] src;
    logic [WORD_W-1:0] dst;

    assign src = r_s1.src_value;
    assign dst = r_s1.dst_value;

    assign s1_advance  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || s1_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Shared adder: subtract forms use the inverted source.
    always_comb begin
        is_sub  = r_s1.op inside {OP_SUBC, OP_SUB, OP_CMP};
        add_b   = is_sub ? ~src : src;
        add_cin = 1'b0;
        if (r_s1.op inside {OP_ADDC, OP_SUBC}) begin
            add_cin = r_flags.c;
        end else if (r_s1.op inside {OP_SUB, OP_CMP}) begin
            add_cin = 1'b1;
        end
        sum = {1'b0, dst} + {1'b0, add_b} + {{WORD_W{1'b0}}, add_cin};
        add_flags.c = sum[WORD_W];
        add_flags.z = (sum[WORD_W-1:0] == '0);
        add_flags.n = sum[WORD_W-1];
        add_flags.v = ~(dst[WORD_W-1] ^ add_b[WORD_W-1])
                    & (dst[WORD_W-1] ^ sum[WORD_W-1]);
    end

    always_comb begin
        n_out.result     = '0;
        n_out.write_back = 1'b1;
        n_flags          = r_flags;
        case (r_s1.op)
            OP_RRC: begin
                n_out.result = {r_flags.c, dst[WORD_W-1:1]};
                n_flags.c    = dst[0];
                n_flags.v    = 1'b0;
            end
            OP_SWPB: n_out.result = {dst[7:0], dst[WORD_W-1:8]};
            OP_RRA: begin
                n_out.result = (dst & SIGN_MASK) | {1'b0, dst[WORD_W-1:1]};
                n_flags.c    = dst[0];
                n_flags.v    = 1'b0;
            end
            OP_SXT: begin
                n_out.result = dst[7] ? (HIGH_BYTE | {8'h00, dst[7:0]})
                                      : {8'h00, dst[7:0]};
                n_flags.v    = 1'b0;
            end
            OP_MOV: n_out.result = src;
            OP_ADD, OP_ADDC, OP_SUBC, OP_SUB: begin
                n_out.result = sum[WORD_W-1:0];
                n_flags      = add_flags;
            end
            OP_CMP: begin
                n_out.result     = sum[WORD_W-1:0];
                n_out.write_back = 1'b0;
                n_flags          = add_flags;
            end
            OP_BIT: begin
                n_out.result     = dst & src;
                n_out.write_back = 1'b0;
                n_flags.v        = 1'b0;
            end
            OP_BIC: n_out.result = dst & ~src;
            OP_BIS: n_out.result = dst | src;
            OP_XOR: begin
                n_out.result = dst ^ src;
                n_flags.v    = dst[WORD_W-1] & src[WORD_W-1];
            end
            OP_AND: begin
                n_out.result = dst & src;
                n_flags.v    = 1'b0;
            end
            default: n_out.write_back = 1'b0;
        endcase

        // N and Z follow the result for every flag-setting non-adder op.
        if (r_s1.op inside {OP_RRC, OP_RRA, OP_SXT, OP_BIT, OP_XOR, OP_AND}) begin
            n_flags.z = (n_out.result == '0);
            n_flags.n = n_out.result[WORD_W-1];
        end
        // Logic-style ops: carry is the inverse of zero.
        if (r_s1.op inside {OP_SXT, OP_BIT, OP_XOR, OP_AND}) begin
            n_flags.c = ~n_flags.z;
        end

        n_out.carry_out    = n_flags.c;
        n_out.zero_out     = n_flags.z;
        n_out.negative_out = n_flags.n;
        n_out.overflow_out = n_flags.v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_advance) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_flags;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1 <= i_in_word;
        end
        if (s1_advance) begin
            r_out <= n_out;
        end
    end

    // Flags only move when a word enters the result register.
    `ALU_ASSERT(a_flags_hold, i_clk, i_rst_n, !s1_advance |=> $stable(r_flags))
    // The word on the output always carries the current flag state.
    `ALU_ASSERT(a_out_flags_match, i_clk, i_rst_n, r_out_valid |-> (r_flags == {r_out.overflow_out, r_out.negative_out, r_out.zero_out, r_out.carry_out}))
    // Compare and bit test never write back.
    `ALU_ASSERT(a_no_wb_cmp_bit, i_clk, i_rst_n, (s1_advance && (r_s1.op == OP_CMP || r_s1.op == OP_BIT)) |=> !r_out.write_back)
    // An empty input register can always take a word.
    `ALU_ASSERT_ALWAYS(a_empty_ready, i_clk, !r_s1_valid |-> o_in_ready)

endmodule
